// File: design/nmit_pkg.sv
// shared types and constants for the normal matrix inverse-transpose core
package nmit_pkg;

    // element and intermediate widths
    localparam int A_W           = 32;
    localparam int COF_W         = 64;
    localparam int DW            = 97;
    localparam int QW            = 34;
    localparam int THR_W         = 17;
    localparam int N_ELEM        = 9;
    localparam int FRAC_BITS_DEF = 16;

    // pipeline depths
    localparam int COF_LAT = 2;
    localparam int DET_LAT = 4;
    localparam int LAT     = COF_LAT + DET_LAT + QW + 1;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

    typedef logic signed [A_W-1:0]   t_elem;
    typedef logic signed [COF_W-1:0] t_cof;
    typedef logic [DW-1:0]           t_dmag;

    // determinant info handed to the division lanes
    typedef struct packed {
        logic  degen;
        logic  dneg;
        t_dmag dmag;
    } t_det_info;

    // per-lane status handed to the merge stage
    typedef struct packed {
        logic degen;
        logic sat;
    } t_lane_flags;

endpackage

// File: design/nmit_in_if.sv
// input channel carrying one source matrix word
interface nmit_in_if;
    import nmit_pkg::*;

    logic  valid;
    logic  ready;
    t_elem in_r0_c0;
    t_elem in_r0_c1;
    t_elem in_r0_c2;
    t_elem in_r1_c0;
    t_elem in_r1_c1;
    t_elem in_r1_c2;
    t_elem in_r2_c0;
    t_elem in_r2_c1;
    t_elem in_r2_c2;

    modport source (
        output valid, in_r0_c0, in_r0_c1, in_r0_c2, in_r1_c0, in_r1_c1, in_r1_c2,
               in_r2_c0, in_r2_c1, in_r2_c2,
        input  ready
    );
    modport sink (
        input  valid, in_r0_c0, in_r0_c1, in_r0_c2, in_r1_c0, in_r1_c1, in_r1_c2,
               in_r2_c0, in_r2_c1, in_r2_c2,
        output ready
    );
endinterface

// File: design/nmit_out_if.sv
// output channel carrying one inverse-transpose word
interface nmit_out_if;
    import nmit_pkg::*;

    logic  valid;
    logic  ready;
    t_elem res_r0_c0;
    t_elem res_r0_c1;
    t_elem res_r0_c2;
    t_elem res_r1_c0;
    t_elem res_r1_c1;
    t_elem res_r1_c2;
    t_elem res_r2_c0;
    t_elem res_r2_c1;
    t_elem res_r2_c2;
    logic  degenerate;
    logic  saturated;

    modport source (
        output valid, res_r0_c0, res_r0_c1, res_r0_c2, res_r1_c0, res_r1_c1, res_r1_c2,
               res_r2_c0, res_r2_c1, res_r2_c2, degenerate, saturated,
        input  ready
    );
    modport sink (
        input  valid, res_r0_c0, res_r0_c1, res_r0_c2, res_r1_c0, res_r1_c1, res_r1_c2,
               res_r2_c0, res_r2_c1, res_r2_c2, degenerate, saturated,
        output ready
    );
endinterface

// File: design/nmit_cof_lane.sv
// one cofactor lane: two products and their difference
module nmit_cof_lane (
    input  logic           i_clk,
    input  logic           i_en,
    input  nmit_pkg::t_elem i_a,
    input  nmit_pkg::t_elem i_b,
    input  nmit_pkg::t_elem i_c,
    input  nmit_pkg::t_elem i_d,
    output nmit_pkg::t_cof  o_cof
);
    import nmit_pkg::*;

    t_cof r_p0;
    t_cof r_p1;
    t_cof r_cof;

    // products, then difference
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0  <= COF_W'(i_a) * COF_W'(i_b);
            r_p1  <= COF_W'(i_c) * COF_W'(i_d);
            r_cof <= r_p0 - r_p1;
        end
    end

    assign o_cof = r_cof;
endmodule

// File: design/nmit_det.sv
// determinant from row 0 and its cofactors, magnitude and degenerate test
module nmit_det #(
    parameter int FRAC_BITS = nmit_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  nmit_pkg::t_elem              i_a   [3],
    input  nmit_pkg::t_cof               i_cof [3],
    input  logic [nmit_pkg::THR_W-1:0]   i_thr,
    output nmit_pkg::t_det_info          o_info
);
    import nmit_pkg::*;

    localparam int SW = DW + 1;

    logic signed [63:0]   r_phi  [3];
    logic signed [64:0]   r_plo  [3];
    logic signed [SW-1:0] r_term [3];
    logic signed [SW-1:0] r_det;
    t_det_info            r_info;

    logic signed [SW-1:0] n_det_neg;
    t_dmag                n_mag;
    t_dmag                n_thr;

    // partial products of element times cofactor, split at bit 32
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_phi[k]  <= 64'(i_a[k]) * 64'(signed'(i_cof[k][63:32]));
                r_plo[k]  <= 65'(i_a[k]) * signed'({33'd0, i_cof[k][31:0]});
                r_term[k] <= (SW'(r_phi[k]) <<< 32) + SW'(r_plo[k]);
            end
            r_det <= r_term[0] + r_term[1] + r_term[2];
        end
    end

    // magnitude and threshold compare
    always_comb begin
        n_det_neg = -r_det;
        n_mag     = r_det[SW-1] ? n_det_neg[DW-1:0] : r_det[DW-1:0];
        n_thr     = DW'(i_thr) << (2 * FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_info.dneg  <= r_det[SW-1];
            r_info.dmag  <= n_mag;
            r_info.degen <= (n_mag == '0) || (n_mag < n_thr);
        end
    end

    assign o_info = r_info;
endmodule

// File: design/nmit_div_lane.sv
// one division lane: restoring divide of a cofactor by the determinant, one quotient bit a stage
module nmit_div_lane #(
    parameter int FRAC_BITS = nmit_pkg::FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  nmit_pkg::t_cof         i_cof,
    input  nmit_pkg::t_det_info    i_info,
    output nmit_pkg::t_elem        o_res,
    output nmit_pkg::t_lane_flags  o_flags
);
    import nmit_pkg::*;

    localparam int NW = COF_W + 2 * FRAC_BITS;
    localparam int CW = (NW > DW + QW) ? NW : DW + QW;

    logic [COF_W-1:0] r_mag_dly [DET_LAT];
    logic             r_neg_dly [DET_LAT];

    logic [CW-1:0]    r_rem   [QW];
    logic [QW-1:0]    r_q     [QW];
    t_dmag            r_d     [QW];
    logic             r_neg   [QW];
    logic             r_degen [QW];

    t_elem            r_res;
    t_lane_flags      r_flags;

    logic [COF_W-1:0] n_mag;
    logic [QW-1:0]    n_lim;
    logic             n_sat;
    logic [A_W-1:0]   n_m;

    // cofactor magnitude and sign wait for the determinant
    assign n_mag = i_cof[COF_W-1] ? COF_W'(-i_cof) : COF_W'(i_cof);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag_dly[0] <= n_mag;
            r_neg_dly[0] <= i_cof[COF_W-1];
            for (int k = 1; k < DET_LAT; k++) begin
                r_mag_dly[k] <= r_mag_dly[k-1];
                r_neg_dly[k] <= r_neg_dly[k-1];
            end
        end
    end

    // divide stages, quotient bit QW-1-k in stage k
    for (genvar k = 0; k < QW; k++) begin : g_stg
        localparam int SH = QW - 1 - k;

        logic [CW-1:0] w_rem;
        logic [QW-1:0] w_q;
        t_dmag         w_d;
        logic          w_neg;
        logic          w_degen;
        logic [CW-1:0] w_dsh;
        logic          w_ge;

        if (k == 0) begin : g_first
            assign w_rem   = CW'(r_mag_dly[DET_LAT-1]) << (2 * FRAC_BITS);
            assign w_q     = '0;
            assign w_d     = i_info.dmag;
            assign w_neg   = r_neg_dly[DET_LAT-1] ^ i_info.dneg;
            assign w_degen = i_info.degen;
        end else begin : g_next
            assign w_rem   = r_rem[k-1];
            assign w_q     = r_q[k-1];
            assign w_d     = r_d[k-1];
            assign w_neg   = r_neg[k-1];
            assign w_degen = r_degen[k-1];
        end

        assign w_dsh = CW'(w_d) << SH;
        assign w_ge  = (w_rem >= w_dsh);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]   <= w_ge ? (w_rem - w_dsh) : w_rem;
                r_q[k]     <= w_q | (QW'(w_ge) << SH);
                r_d[k]     <= w_d;
                r_neg[k]   <= w_neg;
                r_degen[k] <= w_degen;
            end
        end
    end

    // clamp to the signed range and apply sign
    always_comb begin
        n_lim = r_neg[QW-1] ? (QW'(1) << (A_W - 1)) : ((QW'(1) << (A_W - 1)) - QW'(1));
        n_sat = r_q[QW-1] > n_lim;
        n_m   = n_sat ? n_lim[A_W-1:0] : r_q[QW-1][A_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res         <= r_neg[QW-1] ? t_elem'(-n_m) : t_elem'(n_m);
            r_flags.sat   <= n_sat;
            r_flags.degen <= r_degen[QW-1];
        end
    end

    assign o_res   = r_res;
    assign o_flags = r_flags;
endmodule

// File: design/normal_matrix_inverse_transpose_core.sv
// 3x3 inverse-transpose by cofactors, from accepted word to result word
// throughput one word per cycle; nine division lanes each resolve one quotient bit a stage
// (34 stages), after two cofactor stages and four determinant stages
// the whole pipeline holds while the output word waits; synchronous active-low reset
// clears the valid bits and loads the threshold register with 1
module normal_matrix_inverse_transpose_core #(
    parameter int FRAC_BITS = nmit_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [nmit_pkg::THR_W-1:0]  i_cfg_wdata,
    nmit_in_if.sink                     i_in,
    nmit_out_if.source                  o_out
);
    import nmit_pkg::*;

    logic [THR_W-1:0] r_thr;
    logic [LAT-1:0]   r_vld;
    t_elem            r_a_dly [COF_LAT][3];

    logic             w_en;
    t_elem            w_a     [N_ELEM];
    t_cof             w_cof   [N_ELEM];
    t_elem            w_row0  [3];
    t_cof             w_cof0  [3];
    t_det_info        w_info;
    t_elem            w_res   [N_ELEM];
    t_lane_flags      w_flags [N_ELEM];
    t_elem            w_out   [N_ELEM];
    logic [N_ELEM-1:0] w_sats;

    // pipeline advances unless the output word is stalled
    assign w_en       = !r_vld[LAT-1] || o_out.ready;
    assign i_in.ready = w_en && i_rst_n;

    assign w_a[0] = i_in.in_r0_c0;
    assign w_a[1] = i_in.in_r0_c1;
    assign w_a[2] = i_in.in_r0_c2;
    assign w_a[3] = i_in.in_r1_c0;
    assign w_a[4] = i_in.in_r1_c1;
    assign w_a[5] = i_in.in_r1_c2;
    assign w_a[6] = i_in.in_r2_c0;
    assign w_a[7] = i_in.in_r2_c1;
    assign w_a[8] = i_in.in_r2_c2;

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    // valid tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_in.valid};
        end
    end

    // row 0 waits for the cofactors
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < 3; j++) begin
                r_a_dly[0][j] <= w_a[j];
                for (int s = 1; s < COF_LAT; s++) begin
                    r_a_dly[s][j] <= r_a_dly[s-1][j];
                end
            end
        end
    end

    // cofactor lanes
    for (genvar r = 0; r < 3; r++) begin : g_row
        for (genvar c = 0; c < 3; c++) begin : g_col
            localparam int R1 = (r + 1) % 3;
            localparam int R2 = (r + 2) % 3;
            localparam int C1 = (c + 1) % 3;
            localparam int C2 = (c + 2) % 3;

            nmit_cof_lane u_cof (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_a   (w_a[R1*3 + C1]),
                .i_b   (w_a[R2*3 + C2]),
                .i_c   (w_a[R1*3 + C2]),
                .i_d   (w_a[R2*3 + C1]),
                .o_cof (w_cof[r*3 + c])
            );
        end
    end

    for (genvar j = 0; j < 3; j++) begin : g_row0
        assign w_row0[j] = r_a_dly[COF_LAT-1][j];
        assign w_cof0[j] = w_cof[j];
    end

    nmit_det #(.FRAC_BITS(FRAC_BITS)) u_det (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_a    (w_row0),
        .i_cof  (w_cof0),
        .i_thr  (r_thr),
        .o_info (w_info)
    );

    // division lanes and merge
    for (genvar k = 0; k < N_ELEM; k++) begin : g_lane
        nmit_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_cof   (w_cof[k]),
            .i_info  (w_info),
            .o_res   (w_res[k]),
            .o_flags (w_flags[k])
        );

        if (k % 4 == 0) begin : g_diag
            assign w_out[k] = w_flags[k].degen ? (t_elem'(1) <<< FRAC_BITS) : w_res[k];
        end else begin : g_off
            assign w_out[k] = w_flags[k].degen ? t_elem'(0) : w_res[k];
        end
        assign w_sats[k] = w_flags[k].sat;
    end

    assign o_out.valid      = r_vld[LAT-1];
    assign o_out.res_r0_c0  = w_out[0];
    assign o_out.res_r0_c1  = w_out[1];
    assign o_out.res_r0_c2  = w_out[2];
    assign o_out.res_r1_c0  = w_out[3];
    assign o_out.res_r1_c1  = w_out[4];
    assign o_out.res_r1_c2  = w_out[5];
    assign o_out.res_r2_c0  = w_out[6];
    assign o_out.res_r2_c1  = w_out[7];
    assign o_out.res_r2_c2  = w_out[8];
    assign o_out.degenerate = w_flags[0].degen;
    assign o_out.saturated  = !w_flags[0].degen && (|w_sats);
endmodule

// File: verif/nmit_tb_if.sv
// testbench word types for source matrices and inverse-transpose results
`timescale 1ns / 100ps
package nmit_tb_pkg;
    import nmit_pkg::*;

    // one source matrix word
    typedef struct {
        t_elem m [9];
    } t_matrix_word;

    // one inverse-transpose word with flags
    typedef struct {
        t_elem r [9];
        logic  degen;
        logic  sat;
    } t_invt_word;
endpackage

// File: verif/testbench.sv
// self-checking testbench for the normal matrix inverse-transpose core
`timescale 1ns / 100ps
module testbench;
    import nmit_pkg::*;
    import nmit_tb_pkg::*;

    localparam int FB          = FRAC_BITS_DEF;
    localparam int N_RANDOM    = 1200;
    localparam int STALL_LIMIT = 5000;
    localparam int N_DIRECTED  = 14;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [THR_W-1:0] i_cfg_wdata;

    nmit_in_if  in_ch ();
    nmit_out_if out_ch ();

    normal_matrix_inverse_transpose_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch.sink),
        .o_out       (out_ch.source)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    logic [THR_W-1:0] thr_shadow;
    t_invt_word       invt_expected_q [$];
    int               n_errors;
    int               idle_cycles;
    bit               quiet_phase;
    bit               sink_hold_long;

    // inverse-transpose by cofactors, exact quotient truncated toward zero
    function automatic t_invt_word predict_invt(t_matrix_word w, logic [THR_W-1:0] thr);
        t_invt_word        res;
        logic signed [63:0] a [9];
        logic signed [63:0] cof [9];
        logic signed [127:0] det;
        logic [127:0]       dmag;
        logic [127:0]       thr_w;
        logic [127:0]       num;
        logic [127:0]       quo;
        logic [63:0]        cmag;
        logic [31:0]        lim;
        logic [31:0]        m;
        bit                 neg;
        int                 r1, r2, c1, c2;
        for (int k = 0; k < 9; k++) a[k] = w.m[k];
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                r1 = (r + 1) % 3; r2 = (r + 2) % 3;
                c1 = (c + 1) % 3; c2 = (c + 2) % 3;
                cof[r*3+c] = a[r1*3+c1] * a[r2*3+c2] - a[r1*3+c2] * a[r2*3+c1];
            end
        end
        det = 128'(signed'(a[0])) * 128'(signed'(cof[0]))
            + 128'(signed'(a[1])) * 128'(signed'(cof[1]))
            + 128'(signed'(a[2])) * 128'(signed'(cof[2]));
        dmag  = det[127] ? 128'(-det) : 128'(det);
        thr_w = 128'(thr) << (2 * FB);
        res.sat = 1'b0;
        if (dmag == 0 || dmag < thr_w) begin
            for (int k = 0; k < 9; k++) res.r[k] = (k % 4 == 0) ? t_elem'(1 << FB) : '0;
            res.degen = 1'b1;
            return res;
        end
        res.degen = 1'b0;
        for (int k = 0; k < 9; k++) begin
            neg  = (cof[k] < 0) != det[127];
            cmag = cof[k] < 0 ? 64'(-cof[k]) : 64'(cof[k]);
            num  = 128'(cmag) << (2 * FB);
            quo  = num / dmag;
            lim  = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            if (quo > 128'(lim)) begin
                m = lim;
                res.sat = 1'b1;
            end else begin
                m = quo[31:0];
            end
            res.r[k] = neg ? t_elem'(-m) : t_elem'(m);
        end
        return res;
    endfunction

    // element-wise match of two result words, flags included
    function automatic bit same_word(t_invt_word x, t_invt_word y);
        bit eq;
        eq = (x.degen === y.degen) && (x.sat === y.sat);
        for (int k = 0; k < 9; k++)
            if (x.r[k] !== y.r[k]) eq = 1'b0;
        return eq;
    endfunction

    function automatic t_elem rand_elem();
        case ($urandom_range(0, 5))
            0: return t_elem'($urandom);
            1: return t_elem'($urandom_range(0, 8) << FB) - t_elem'(4 << FB);
            2: return t_elem'($urandom_range(0, 32'h3_FFFF)) - t_elem'(32'h2_0000);
            3: return ($urandom_range(0, 1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return t_elem'(int'($urandom_range(0, 32'h7_FFFF)) - 32'h4_0000);
        endcase
    endfunction

    function automatic t_matrix_word rand_matrix();
        t_matrix_word w;
        int           mode;
        mode = $urandom_range(0, 9);
        for (int k = 0; k < 9; k++) w.m[k] = rand_elem();
        // near-diagonal, well-conditioned
        if (mode < 4) begin
            for (int k = 0; k < 9; k++) begin
                w.m[k] = (k % 4 == 0) ? t_elem'($urandom_range(1, 16) << (FB - 2))
                                      : t_elem'(int'($urandom_range(0, 8191)) - 4096);
                if (k % 4 == 0 && $urandom_range(0, 1)) w.m[k] = -w.m[k];
            end
        // singular: repeated row
        end else if (mode == 4) begin
            for (int k = 0; k < 3; k++) w.m[6+k] = w.m[3+k];
        end
        return w;
    endfunction

    task automatic drive_word(t_matrix_word w);
        in_ch.valid    <= 1'b1;
        in_ch.in_r0_c0 <= w.m[0]; in_ch.in_r0_c1 <= w.m[1]; in_ch.in_r0_c2 <= w.m[2];
        in_ch.in_r1_c0 <= w.m[3]; in_ch.in_r1_c1 <= w.m[4]; in_ch.in_r1_c2 <= w.m[5];
        in_ch.in_r2_c0 <= w.m[6]; in_ch.in_r2_c1 <= w.m[7]; in_ch.in_r2_c2 <= w.m[8];
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        invt_expected_q.insert(invt_expected_q.size(), predict_invt(w, thr_shadow));
        @(negedge i_clk);
    endtask

    // send one word, sometimes with a random gap afterwards outside the quiet phase
    task automatic send_word(t_matrix_word w);
        drive_word(w);
        if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
    endtask

    task automatic write_threshold(logic [THR_W-1:0] v);
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (invt_expected_q.size() != 0) @(negedge i_clk);
        repeat (LAT + 4) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        thr_shadow  = v;
    endtask

    // sink side: random stalls, one long hold-off
    initial begin
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (sink_hold_long) begin
                out_ch.ready <= 1'b0;
                repeat (LAT + 30) @(negedge i_clk);
                sink_hold_long = 1'b0;
                out_ch.ready <= 1'b1;
            end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 5) - 1) @(negedge i_clk);
                @(negedge i_clk);
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // result checker and idle watchdog
    always @(posedge i_clk) begin
        t_invt_word got;
        t_invt_word want;
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > STALL_LIMIT) begin
                $display("testbench NOT OK");
                $finish;
            end
            if (out_ch.valid && out_ch.ready) begin
                got.r[0] = out_ch.res_r0_c0; got.r[1] = out_ch.res_r0_c1;
                got.r[2] = out_ch.res_r0_c2; got.r[3] = out_ch.res_r1_c0;
                got.r[4] = out_ch.res_r1_c1; got.r[5] = out_ch.res_r1_c2;
                got.r[6] = out_ch.res_r2_c0; got.r[7] = out_ch.res_r2_c1;
                got.r[8] = out_ch.res_r2_c2;
                got.degen = out_ch.degenerate;
                got.sat   = out_ch.saturated;
                if (invt_expected_q.size() == 0) begin
                    $display("%0t: unexpected word, actual r00 %h", $time, got.r[0]);
                    n_errors++;
                end else begin
                    want = invt_expected_q.pop_front();
                    for (int k = 0; k < 9; k++)
                        if (got.r[k] !== want.r[k]) begin
                            $display("%0t: element %0d expected %h actual %h",
                                     $time, k, want.r[k], got.r[k]);
                            n_errors++;
                        end
                    if (got.degen !== want.degen || got.sat !== want.sat) begin
                        $display("%0t: flags degen/sat expected %b%b actual %b%b",
                                 $time, want.degen, want.sat, got.degen, got.sat);
                        n_errors++;
                    end
                end
            end
        end
    end

    // directed table: matrix and typed expectation where obvious
    t_matrix_word dir_word [N_DIRECTED];
    bit           dir_known [N_DIRECTED];
    t_invt_word   dir_expect [N_DIRECTED];

    initial begin
        t_matrix_word w;
        t_invt_word   ident;
        n_errors       = 0;
        idle_cycles    = 0;
        quiet_phase    = 1'b0;
        sink_hold_long = 1'b0;
        thr_shadow     = THR_RESET;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        in_ch.valid    = 1'b0;
        {in_ch.in_r0_c0, in_ch.in_r0_c1, in_ch.in_r0_c2} = '0;
        {in_ch.in_r1_c0, in_ch.in_r1_c1, in_ch.in_r1_c2} = '0;
        {in_ch.in_r2_c0, in_ch.in_r2_c1, in_ch.in_r2_c2} = '0;
        for (int k = 0; k < 9; k++) ident.r[k] = (k % 4 == 0) ? t_elem'(1 << FB) : '0;
        ident.degen = 1'b1;
        ident.sat   = 1'b0;

        // build the directed table
        for (int i = 0; i < N_DIRECTED; i++) begin
            for (int k = 0; k < 9; k++) dir_word[i].m[k] = '0;
            dir_known[i] = 1'b0;
        end
        // zero matrix: degenerate
        dir_known[0] = 1'b1; dir_expect[0] = ident;
        // identity maps to identity, not degenerate
        for (int k = 0; k < 9; k += 4) dir_word[1].m[k] = 1 << FB;
        dir_known[1] = 1'b1; dir_expect[1] = ident; dir_expect[1].degen = 1'b0;
        // all max positive: singular
        for (int k = 0; k < 9; k++) dir_word[2].m[k] = 32'h7FFF_FFFF;
        dir_known[2] = 1'b1; dir_expect[2] = ident;
        // all min negative: singular
        for (int k = 0; k < 9; k++) dir_word[3].m[k] = 32'h8000_0000;
        dir_known[3] = 1'b1; dir_expect[3] = ident;
        // tiny diagonal: degenerate at the reset threshold
        for (int k = 0; k < 9; k += 4) dir_word[4].m[k] = 32'h0000_0100;
        // big diagonal with min negative
        for (int k = 0; k < 9; k += 4) dir_word[5].m[k] = 32'h8000_0000;
        // diagonal of max, other signs
        for (int k = 0; k < 9; k += 4) dir_word[6].m[k] = 32'h7FFF_FFFF;
        dir_word[6].m[1] = 32'hFFFF_FFFF; dir_word[6].m[3] = 32'h8000_0000;
        // scaled identity, negative
        for (int k = 0; k < 9; k += 4) dir_word[7].m[k] = -(2 << FB);
        // all ones, then two bit patterns
        for (int k = 0; k < 9; k++) dir_word[8].m[k] = 32'hFFFF_FFFF;
        for (int k = 0; k < 9; k++) dir_word[9].m[k] = 32'h5555_AAAA ^ (k << 20);
        for (int k = 0; k < 9; k++) dir_word[10].m[k] = 32'hAAAA_5555 + (k * 32'h0123_4567);
        // determinant just under one: degenerate at a threshold of one (65536)
        dir_word[11].m[0] = 1 << FB; dir_word[11].m[4] = 1 << FB;
        dir_word[11].m[8] = (1 << FB) - 1;
        // permutation matrix
        dir_word[12].m[1] = 1 << FB; dir_word[12].m[3] = 1 << FB;
        dir_word[12].m[8] = 1 << FB;
        dir_word[13].m[0] = 3 << FB; dir_word[13].m[4] = 1 << (FB - 3);
        dir_word[13].m[8] = -(5 << FB); dir_word[13].m[2] = 7;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part at the reset threshold, then at the extremes
        for (int pass = 0; pass < 3; pass++) begin
            for (int i = 0; i < N_DIRECTED; i++) begin
                send_word(dir_word[i]);
                if (dir_known[i] && pass == 0) begin
                    if (!same_word(invt_expected_q[$], dir_expect[i])) begin
                        $display("%0t: table row %0d expected degen %b actual model %b",
                                 $time, i, dir_expect[i].degen, invt_expected_q[$].degen);
                        n_errors++;
                    end
                end
            end
            write_threshold(pass == 0 ? THR_W'(0) : THR_W'(17'h1_FFFF));
        end
        write_threshold(THR_W'(65536));

        // long receiver hold-off while words keep coming
        sink_hold_long = 1'b1;
        for (int i = 0; i < LAT + 20; i++) send_word(rand_matrix());

        // random part across several thresholds
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 250 == 249) begin
                case ($urandom_range(0, 3))
                    0: write_threshold('0);
                    1: write_threshold(THR_W'(1));
                    2: write_threshold(THR_W'(65536));
                    default: write_threshold(THR_W'($urandom_range(0, 17'h1_FFFF)));
                endcase
            end
            if (i > N_RANDOM - 150) quiet_phase = 1'b1;
            w = rand_matrix();
            send_word(w);
        end
        in_ch.valid <= 1'b0;

        // drain
        while (invt_expected_q.size() != 0) @(negedge i_clk);
        repeat (LAT + 10) @(negedge i_clk);
        if (n_errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end
endmodule

// File: filelist.f
design/nmit_pkg.sv
design/nmit_in_if.sv
design/nmit_out_if.sv
design/nmit_cof_lane.sv
design/nmit_det.sv
design/nmit_div_lane.sv
design/normal_matrix_inverse_transpose_core.sv
verif/nmit_tb_if.sv
verif/testbench.sv
